// File: rtl/b2da_pkg.sv
// Shared constants, types and power-of-ten table for the binary to ASCII decimal converter.
package b2da_pkg;

   localparam int unsigned NumPowers  = 10;
   localparam int unsigned NumDigits  = 10;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned IdxWidth   = 4;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned CharWidth  = 6;
   localparam int unsigned MultWidth  = ValueWidth + 2;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned PtrWidth   = 1;
   localparam int unsigned CountWidth = 2;

   typedef logic [IdxWidth-1:0]   idx_type;
   typedef logic [ValueWidth-1:0] value_type;

   localparam idx_type UnitsIdx = idx_type'(NumPowers - 1);
   localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

   localparam logic [ValueWidth-1:0] Pow10 [NumPowers] = '{
      32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000, 32'd100000,
      32'd10000, 32'd1000, 32'd100, 32'd10, 32'd1
   };

   // value plus the place of its leading digit
   typedef struct packed {
      value_type value;
      idx_type   start;
   } front_item_type;

endpackage

// File: rtl/binary_to_decimal_ascii_digits_core.sv
// Top level of the binary to ASCII decimal converter.
// Usage:
// - req_ channel takes one unsigned 32-bit value per transfer on req_tdata.
// - rsp_ channel returns the value's decimal digits as ASCII codes, most
//   significant first, leading zeros dropped; zero gives a single '0'.
//   rsp_tlast marks the units digit, the last transfer of each value.
// - First digit: it passes the front register, a queue entry, then the output
//   register before it shows on rsp_tvalid; further digits follow one per
//   cycle while rsp_tready stays high.
// - Each value gives 1 to 10 digits; the digit generator's single divide
//   step per cycle sets the pace. Values queue up and runs follow each other
//   with no gap.
// - A stalled receiver holds the current digit on rsp_tdata; the queue and
//   front register keep taking up to three further values before req_tready
//   drops.
// - Reset is synchronous and empties all stages; no state carries over
//   between values.
module binary_to_decimal_ascii_digits_core
   import b2da_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] char_code, [7:6] zero
   output logic        rsp_tlast
);

   logic           push_valid, push_ready;
   front_item_type push_item;
   logic           pop_valid, pop_ready;
   front_item_type pop_item;

   b2da_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   b2da_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   b2da_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/b2da_front.sv
// Front end: registers an incoming value and finds the place of its leading decimal digit.
module b2da_front
   import b2da_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [31:0]    req_tdata,
   output logic           push_valid,
   input  logic           push_ready,
   output front_item_type push_item
);

   logic      valid_ff, valid_in;
   value_type value_ff;
   logic      take;
   idx_type   start;

   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take ? 1'b1 : (push_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         value_ff <= req_tdata;
      end
   end

   // first power not above the value; zero falls through to the units place
   always_comb begin
      start = UnitsIdx;
      for (int i = NumPowers - 1; i >= 0; i--) begin
         if (value_ff >= Pow10[i]) begin
            start = idx_type'(i);
         end
      end
   end

   assign push_valid      = valid_ff;
   assign push_item.value = value_ff;
   assign push_item.start = start;

endmodule

// File: rtl/b2da_queue.sv
// Two-entry queue between the front end and the digit generator.
module b2da_queue
   import b2da_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  front_item_type push_item,
   output logic           pop_valid,
   input  logic           pop_ready,
   output front_item_type pop_item
);

   front_item_type          entry_ff [QueueDepth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    push, pop;

   assign push_ready = count_ff != CountWidth'(QueueDepth);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + CountWidth'(push) - CountWidth'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QueueDepth))
      else $error("queue count out of range");

endmodule

// File: rtl/b2da_back.sv
// Back end: emits one ASCII digit per cycle unless stalled, dividing the remainder by the current power of ten.
module b2da_back
   import b2da_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  front_item_type pop_item,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [7:0]     rsp_tdata,
   output logic           rsp_tlast
);

   logic                   busy_ff, busy_in;
   value_type              rem_ff, rem_in;
   idx_type                idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CharWidth-1:0]   char_ff;
   logic                   last_ff;

   logic [MultWidth-1:0]   mult_tab [NumPowers][NumDigits];
   value_type              cur_rem;
   idx_type                cur_idx, idx_safe;
   logic [NumDigits-2:0]   ge;
   logic [DigitWidth-1:0]  digit;
   logic [MultWidth-1:0]   sub;
   logic                   advance, emit, last;

   // k times each power of ten, all worked out at elaboration
   for (genvar i = 0; i < NumPowers; i++) begin : g_pow
      for (genvar k = 0; k < NumDigits; k++) begin : g_mult
         localparam logic [MultWidth-1:0] Mult = MultWidth'(k) * MultWidth'(Pow10[i]);
         assign mult_tab[i][k] = Mult;
      end
   end

   assign advance   = !out_valid_ff || rsp_tready;
   assign emit      = advance && (busy_ff || pop_valid);
   assign pop_ready = advance && !busy_ff;

   assign cur_rem  = busy_ff ? rem_ff : pop_item.value;
   assign cur_idx  = busy_ff ? idx_ff : pop_item.start;
   assign idx_safe = (cur_idx > UnitsIdx) ? UnitsIdx : cur_idx;
   assign last     = cur_idx == UnitsIdx;

   // digit is the number of multiples of the power that fit into the remainder
   always_comb begin
      digit = '0;
      for (int k = 1; k < NumDigits; k++) begin
         ge[k-1] = {2'b00, cur_rem} >= mult_tab[idx_safe][k];
         digit   = digit + DigitWidth'(ge[k-1]);
      end
   end

   assign sub    = mult_tab[idx_safe][digit];
   assign rem_in = cur_rem - sub[ValueWidth-1:0];
   assign idx_in = cur_idx + 1'b1;

   always_comb begin
      busy_in = busy_ff;
      if (emit) begin
         busy_in = !last;
      end
   end

   assign out_valid_in = advance ? emit : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      if (emit) begin
         rem_ff  <= rem_in;
         idx_ff  <= idx_in;
         char_ff <= AsciiZero + CharWidth'(digit);
         last_ff <= last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, char_ff};
   assign rsp_tlast  = last_ff;

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff != '0 && idx_ff <= UnitsIdx))
      else $error("digit place out of range during a run");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> !busy_ff)
      else $error("run continues after its final digit");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      emit |-> digit <= DigitWidth'(NumDigits - 1))
      else $error("digit above nine");

endmodule
